// ===== src/vbmf_pkg.sv =====
package vbmf_pkg;

  // volume geometry
  localparam int DIM_X      = 32;
  localparam int DIM_Y      = 32;
  localparam int DIM_Z      = 32;
  localparam int MAX_RADIUS = 4;

  localparam int DEPTH  = DIM_X * DIM_Y * DIM_Z;
  localparam int ADDR_W = $clog2(DEPTH);

  // field widths fixed by the interface
  localparam int VOX_W   = 16;
  localparam int COORD_W = 5;
  localparam int SIZE_W  = 6;
  localparam int RAD_W   = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  // window voxel count and accumulator widths
  localparam int CNT_MAX = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
  localparam int CNT_W   = $clog2(CNT_MAX + 1);
  localparam int SUM_W   = VOX_W + CNT_W;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd3;

  // input kind codes
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef logic [SIZE_W-1:0] span_t;
  typedef logic [ADDR_W-1:0] addr_t;

  // size saturated to 1..dim
  function automatic span_t clamp_size(input logic [SIZE_W-1:0] s, input int dim);
    span_t res;
    if (s == '0) begin
      res = span_t'(1);
    end else if (int'(s) > dim) begin
      res = span_t'(dim);
    end else begin
      res = s;
    end
    return res;
  endfunction

  // radius saturated to 1..MAX_RADIUS
  function automatic logic [RAD_W-1:0] clamp_radius(input logic [RAD_W-1:0] r);
    logic [RAD_W-1:0] res;
    if (r == '0) begin
      res = RAD_W'(1);
    end else if (int'(r) > MAX_RADIUS) begin
      res = RAD_W'(MAX_RADIUS);
    end else begin
      res = r;
    end
    return res;
  endfunction

  function automatic span_t span_lo(input logic [COORD_W-1:0] c,
                                    input logic [RAD_W-1:0] r);
    span_t res;
    if (span_t'(c) > span_t'(r)) begin
      res = span_t'(c) - span_t'(r);
    end else begin
      res = '0;
    end
    return res;
  endfunction

  function automatic span_t span_hi(input logic [COORD_W-1:0] c,
                                    input logic [RAD_W-1:0] r,
                                    input span_t n);
    span_t top;
    span_t res;
    top = n - span_t'(1);
    if ((span_t'(c) + span_t'(r)) > top) begin
      res = top;
    end else begin
      res = span_t'(c) + span_t'(r);
    end
    return res;
  endfunction

  // linear voxel address, x outermost
  function automatic addr_t addr_of(input span_t x, input span_t y, input span_t z);
    addr_t row;
    row = addr_t'(x) * addr_t'(DIM_Y) + addr_t'(y);
    return row * addr_t'(DIM_Z) + addr_t'(z);
  endfunction

endpackage

// ===== src/volume_box_mean_filter.sv =====
// channel  | direction | handshake            | payload
// in_      | in        | in_valid / in_stall  | kind, coord_x/y/z, voxel_value
// out_     | out       | out_valid / out_stall| mean_value, bad_coordinate
// cfg_     | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// a write transaction is taken without stalling; a query outside the sizes in use skips the walk and the divide
// a query walks the clipped window one voxel per cycle through the ram read port, then
// divides one quotient bit per cycle, passing the drain and start states between the two
// rst_n is synchronous; it resets control state and sets the config registers to full size and radius 1, not the ram
// a finished result sits in the output register while the next item is taken
// in_stall is high for the whole of a query, longer while a stalled result holds the output
module volume_box_mean_filter (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // input transactions
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_kind,
  input  logic [vbmf_pkg::COORD_W-1:0]          in_coord_x,
  input  logic [vbmf_pkg::COORD_W-1:0]          in_coord_y,
  input  logic [vbmf_pkg::COORD_W-1:0]          in_coord_z,
  input  logic signed [vbmf_pkg::VOX_W-1:0]     in_voxel_value,
  // result transactions
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [vbmf_pkg::VOX_W-1:0]     out_mean_value,
  output logic                                  out_bad_coordinate,
  // configuration writes
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [vbmf_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [vbmf_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WALK  = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_START = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  localparam int SW = vbmf_pkg::SUM_W;
  localparam int VW = vbmf_pkg::VOX_W;

  // configuration registers
  logic [vbmf_pkg::SIZE_W-1:0] size_x_r;
  logic [vbmf_pkg::SIZE_W-1:0] size_y_r;
  logic [vbmf_pkg::SIZE_W-1:0] size_z_r;
  logic [vbmf_pkg::RAD_W-1:0]  radius_r;

  // control
  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       out_valid_r;

  // window walk
  vbmf_pkg::span_t i_r, j_r, k_r;
  vbmf_pkg::span_t x0_r, x1_r, y0_r, y1_r, z0_r, z1_r;
  logic                         rd_pend_r;
  logic signed [SW-1:0]         sum_r;
  logic [vbmf_pkg::CNT_W-1:0]   cnt_r;

  // result
  logic signed [VW-1:0] res_mean_r;
  logic                 res_bad_r;
  logic signed [VW-1:0] out_mean_r;
  logic                 out_bad_r;

  // derived
  vbmf_pkg::span_t             nx, ny, nz;
  logic [vbmf_pkg::RAD_W-1:0]  rr;
  logic                        in_fire;
  logic                        coord_ok;
  logic                        last;
  logic                        can_load;
  logic                        ram_we;
  vbmf_pkg::addr_t             waddr;
  vbmf_pkg::addr_t             raddr;
  logic [VW-1:0]               rdata;
  logic                        div_done;
  logic signed [VW-1:0]        div_q;

  assign nx = vbmf_pkg::clamp_size(size_x_r, vbmf_pkg::DIM_X);
  assign ny = vbmf_pkg::clamp_size(size_y_r, vbmf_pkg::DIM_Y);
  assign nz = vbmf_pkg::clamp_size(size_z_r, vbmf_pkg::DIM_Z);
  assign rr = vbmf_pkg::clamp_radius(radius_r);

  assign in_stall = (state_r != S_IDLE);
  assign in_fire  = in_valid & ~in_stall;
  assign coord_ok = (vbmf_pkg::span_t'(in_coord_x) < nx) &&
                    (vbmf_pkg::span_t'(in_coord_y) < ny) &&
                    (vbmf_pkg::span_t'(in_coord_z) < nz);
  assign last     = (i_r == x1_r) && (j_r == y1_r) && (k_r == z1_r);
  assign can_load = ~out_valid_r | ~out_stall;

  // writes happen only in idle and read data is summed only for walk addresses, so the two never meet
  assign ram_we = in_fire && (in_kind == vbmf_pkg::KIND_WRITE) && coord_ok;
  assign waddr  = vbmf_pkg::addr_of(vbmf_pkg::span_t'(in_coord_x),
                                    vbmf_pkg::span_t'(in_coord_y),
                                    vbmf_pkg::span_t'(in_coord_z));
  assign raddr  = vbmf_pkg::addr_of(i_r, j_r, k_r);

  vbmf_ram #(
    .WIDTH (VW),
    .DEPTH (vbmf_pkg::DEPTH)
  ) u_voxels (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (in_voxel_value),
    .raddr (raddr),
    .rdata (rdata)
  );

  vbmf_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == S_START),
    .dividend (sum_r),
    .divisor  (cnt_r),
    .done     (div_done),
    .quotient (div_q)
  );

  // config port is always open; the user must write only while idle, the block does not enforce it
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r <= vbmf_pkg::SIZE_W'(32);
      size_y_r <= vbmf_pkg::SIZE_W'(32);
      size_z_r <= vbmf_pkg::SIZE_W'(32);
      radius_r <= vbmf_pkg::RAD_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        vbmf_pkg::REG_SIZE_X: size_x_r <= cfg_data;
        vbmf_pkg::REG_SIZE_Y: size_y_r <= cfg_data;
        vbmf_pkg::REG_SIZE_Z: size_z_r <= cfg_data;
        vbmf_pkg::REG_RADIUS: radius_r <= cfg_data[vbmf_pkg::RAD_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire && in_kind == vbmf_pkg::KIND_QUERY) begin
          state_nxt = coord_ok ? S_WALK : S_DONE;
        end
      end
      S_WALK: begin
        if (last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: state_nxt = S_START;
      S_START: state_nxt = S_DIV;
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (can_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      // read data arrives in the cycle after the address
      rd_pend_r <= (state_r == S_WALK);
      if (state_r == S_DONE && can_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // window setup, walk counters and accumulation
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_fire) begin
      x0_r  <= vbmf_pkg::span_lo(in_coord_x, rr);
      x1_r  <= vbmf_pkg::span_hi(in_coord_x, rr, nx);
      y0_r  <= vbmf_pkg::span_lo(in_coord_y, rr);
      y1_r  <= vbmf_pkg::span_hi(in_coord_y, rr, ny);
      z0_r  <= vbmf_pkg::span_lo(in_coord_z, rr);
      z1_r  <= vbmf_pkg::span_hi(in_coord_z, rr, nz);
      i_r   <= vbmf_pkg::span_lo(in_coord_x, rr);
      j_r   <= vbmf_pkg::span_lo(in_coord_y, rr);
      k_r   <= vbmf_pkg::span_lo(in_coord_z, rr);
      sum_r <= '0;
      cnt_r <= '0;
    end else begin
      if (state_r == S_WALK) begin
        cnt_r <= cnt_r + vbmf_pkg::CNT_W'(1);
        // z innermost, then y, then x
        if (k_r == z1_r) begin
          k_r <= z0_r;
          if (j_r == y1_r) begin
            j_r <= y0_r;
            i_r <= i_r + vbmf_pkg::span_t'(1);
          end else begin
            j_r <= j_r + vbmf_pkg::span_t'(1);
          end
        end else begin
          k_r <= k_r + vbmf_pkg::span_t'(1);
        end
      end
      if (rd_pend_r) begin
        sum_r <= sum_r + {{(SW - VW){rdata[VW-1]}}, rdata};
      end
    end
  end

  // pending result
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_fire) begin
      res_mean_r <= '0;
      res_bad_r  <= ~coord_ok;
    end else if (state_r == S_DIV && div_done) begin
      res_mean_r <= div_q;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (state_r == S_DONE && can_load) begin
      out_mean_r <= res_mean_r;
      out_bad_r  <= res_bad_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_mean_value     = out_mean_r;
  assign out_bad_coordinate = out_bad_r;

endmodule

// ===== src/vbmf_ram.sv =====
module vbmf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/vbmf_divider.sv =====
module vbmf_divider (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic signed [vbmf_pkg::SUM_W-1:0] dividend,
  input  logic [vbmf_pkg::CNT_W-1:0]        divisor,
  output logic                             done,
  output logic signed [vbmf_pkg::VOX_W-1:0] quotient
);

  localparam int SW    = vbmf_pkg::SUM_W;
  localparam int CW    = vbmf_pkg::CNT_W;
  localparam int STEPW = $clog2(SW);

  logic              busy_r;
  logic              done_r;
  logic [STEPW-1:0]  step_r;
  logic [CW-1:0]     rem_r;
  logic [SW-1:0]     quo_r;
  logic [CW-1:0]     dsr_r;
  logic              neg_r;

  logic [CW:0]       rem_shift;
  logic [CW+1:0]     diff;
  logic              ge;
  logic [SW-1:0]     mag;
  logic [SW-1:0]     signed_q;

  assign mag       = dividend[SW-1] ? (~dividend + SW'(1)) : dividend;
  assign rem_shift = {rem_r, quo_r[SW-1]};
  assign diff      = {1'b0, rem_shift} - {2'b00, dsr_r};
  assign ge        = ~diff[CW+1];
  assign signed_q  = neg_r ? (~quo_r + SW'(1)) : quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && step_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // one quotient bit per cycle, restoring on magnitudes
  always_ff @(posedge clk) begin
    if (start) begin
      step_r <= STEPW'(SW - 1);
      rem_r  <= '0;
      quo_r  <= mag;
      dsr_r  <= divisor;
      neg_r  <= dividend[SW-1];
    end else if (busy_r) begin
      step_r <= step_r - STEPW'(1);
      rem_r  <= ge ? diff[CW-1:0] : rem_shift[CW-1:0];
      quo_r  <= {quo_r[SW-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = signed_q[vbmf_pkg::VOX_W-1:0];

endmodule
